// ===== hw/rtl/dqmb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS query message builder package
// Request types, register indexes, sequencer step addresses and the
// control store of the byte sequencer.
// ----------------------------------------------------------------------------
package dqmb_pkg;

    // Input request: one host name character.
    typedef struct packed {
        logic [7:0] name_char;
        logic       last_char;
    } t_in_req;

    // Output request: one byte of the query message.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_run;
        logic       end_of_message;
        logic       label_truncated;
    } t_out_req;

    // Configuration port.
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        REG_QUERY_ID    = 2'd0,
        REG_QUERY_TYPE  = 2'd1,
        REG_QUERY_CLASS = 2'd2
    } t_reg_idx;

    localparam logic [15:0] QUERY_TYPE_RST  = 16'h0001;
    localparam logic [15:0] QUERY_CLASS_RST = 16'h0001;

    // Message constants.
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [7:0] FLAGS_HI   = 8'h01;
    localparam logic [7:0] QDCOUNT_LO = 8'h01;

    // Sequencer step addresses.
    typedef logic [4:0] t_pc;
    localparam t_pc PC_IDLE     = 5'd0;
    localparam t_pc PC_ID_HI    = 5'd1;
    localparam t_pc PC_ID_LO    = 5'd2;
    localparam t_pc PC_FLAGS_HI = 5'd3;
    localparam t_pc PC_QD_LO    = 5'd6;
    localparam t_pc PC_HDR_END  = 5'd12;
    localparam t_pc PC_LEN      = 5'd13;
    localparam t_pc PC_CHR      = 5'd14;
    localparam t_pc PC_TERM     = 5'd15;
    localparam t_pc PC_QT_HI    = 5'd16;
    localparam t_pc PC_QT_LO    = 5'd17;
    localparam t_pc PC_QC_HI    = 5'd18;
    localparam t_pc PC_QC_LO    = 5'd19;

    // Byte source of a step.
    typedef enum logic [3:0] {
        SRC_CONST,
        SRC_ID_HI,
        SRC_ID_LO,
        SRC_LEN,
        SRC_CHAR,
        SRC_QT_HI,
        SRC_QT_LO,
        SRC_QC_HI,
        SRC_QC_LO
    } t_src;

    // Condition under which a step's byte closes the run of its character.
    typedef enum logic [2:0] {
        EOR_NONE,
        EOR_ALWAYS,
        EOR_HDR_END,
        EOR_LEN_END,
        EOR_CHR_END
    } t_eor;

    // Next-step selection.
    typedef enum logic [2:0] {
        NXT_SEQ,
        NXT_DISPATCH,
        NXT_LEN,
        NXT_CHR,
        NXT_IDLE
    } t_nxt;

    typedef struct packed {
        t_src       src;
        logic [7:0] konst;
        logic       eom;
        logic       trunc;
        t_eor       eor;
        t_nxt       nxt;
    } t_ctrl;

    // Control store: one word per sequencer step.
    function automatic t_ctrl rom_word(t_pc pc);
        t_ctrl w;
        w = '{src: SRC_CONST, konst: BYTE_ZERO, eom: 1'b0, trunc: 1'b0,
              eor: EOR_NONE, nxt: NXT_SEQ};
        case (pc)
            PC_IDLE:     w.nxt = NXT_IDLE;
            PC_ID_HI:    w.src = SRC_ID_HI;
            PC_ID_LO:    w.src = SRC_ID_LO;
            PC_FLAGS_HI: w.konst = FLAGS_HI;
            PC_QD_LO:    w.konst = QDCOUNT_LO;
            PC_HDR_END: begin
                w.eor = EOR_HDR_END;
                w.nxt = NXT_DISPATCH;
            end
            PC_LEN: begin
                w.src   = SRC_LEN;
                w.trunc = 1'b1;
                w.eor   = EOR_LEN_END;
                w.nxt   = NXT_LEN;
            end
            PC_CHR: begin
                w.src   = SRC_CHAR;
                w.trunc = 1'b1;
                w.eor   = EOR_CHR_END;
                w.nxt   = NXT_CHR;
            end
            PC_TERM:     w.konst = BYTE_ZERO;
            PC_QT_HI:    w.src = SRC_QT_HI;
            PC_QT_LO:    w.src = SRC_QT_LO;
            PC_QC_HI:    w.src = SRC_QC_HI;
            PC_QC_LO: begin
                w.src = SRC_QC_LO;
                w.eom = 1'b1;
                w.eor = EOR_ALWAYS;
                w.nxt = NXT_IDLE;
            end
            // Remaining header steps emit zero bytes.
            default: w.konst = BYTE_ZERO;
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/dqmb_label_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label buffer
// Single-port-write, registered-read memory that holds the characters of
// the label being collected.
// ----------------------------------------------------------------------------
module dqmb_label_buf #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/dns_query_message_builder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS query message builder core
// Turns a host name, one character per request, into the bytes of a DNS
// query: header, encoded name, QTYPE and QCLASS.
// ----------------------------------------------------------------------------
// A character request is accepted while the sequencer is idle; a non-dot
// character is written to the label buffer while the label has room. The
// block then walks a small control store, one step per emitted byte, and
// takes no new character until the walk is done: the first character of a
// name costs 12 header bytes, a dot costs 1 + L bytes for a label of L
// characters, and the last character adds the pending label plus 5 bytes of
// terminator, QTYPE and QCLASS. A character that causes no byte leaves the
// input ready. The output register sends one byte per cycle while the output
// is ready; a stalled output holds the sequencer. Labels longer than
// MAX_LABEL are cut and the cut label's bytes are flagged.
// ----------------------------------------------------------------------------
module dns_query_message_builder_core
    import dqmb_pkg::*;
#(
    parameter int unsigned MAX_LABEL = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Character input
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_req           i_in_req,
    // Message byte output
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_req          o_out_req,
    // Configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int unsigned AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
    localparam int unsigned LW = $clog2(MAX_LABEL + 1);

    // Configuration registers.
    logic [15:0] r_query_id;
    logic [15:0] r_query_type;
    logic [15:0] r_query_class;

    // Label and message state.
    logic [LW-1:0] r_len,  n_len;
    logic          r_ovf,  n_ovf;
    logic          r_hdr,  n_hdr;
    logic          r_last;
    logic          r_flush;
    logic [AW-1:0] r_idx,  n_idx;
    t_pc           r_pc,   n_pc;

    // Output register.
    logic          r_out_valid;
    t_out_req      r_out_req;

    logic          cfg_wr;
    logic          accept_in;
    logic          in_dot;
    logic          in_store;
    logic [LW-1:0] in_len;
    logic          in_flush;
    logic          run;
    t_ctrl         ctrl;
    logic          len_zero;
    logic          chr_end;
    t_pc           post_flush;
    logic          flush_done;
    logic [7:0]    step_byte;
    logic          step_eor;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_id    <= '0;
            r_query_type  <= QUERY_TYPE_RST;
            r_query_class <= QUERY_CLASS_RST;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_QUERY_ID:    r_query_id    <= pwdata[15:0];
                REG_QUERY_TYPE:  r_query_type  <= pwdata[15:0];
                REG_QUERY_CLASS: r_query_class <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_QUERY_ID:    prdata = {16'h0000, r_query_id};
            REG_QUERY_TYPE:  prdata = {16'h0000, r_query_type};
            REG_QUERY_CLASS: prdata = {16'h0000, r_query_class};
            default:         prdata = '0;
        endcase
    end

    // Character intake: store or count the overflow, and decide the flush.
    assign o_in_ready = (r_pc == PC_IDLE);
    assign accept_in  = i_in_valid && o_in_ready;
    assign in_dot     = (i_in_req.name_char == CHAR_DOT);
    assign in_store   = !in_dot && (r_len < LW'(MAX_LABEL));
    assign in_len     = r_len + LW'(in_store);
    assign in_flush   = (!i_in_req.last_char && in_dot) ||
                        (i_in_req.last_char && (in_len != '0));

    // Sequencer step decode.
    assign run        = (r_pc != PC_IDLE) && (!r_out_valid || i_out_ready);
    assign ctrl       = rom_word(r_pc);
    assign len_zero   = (r_len == '0);
    assign chr_end    = ((LW'(r_idx) + LW'(1)) == r_len);
    assign post_flush = r_last ? PC_TERM : PC_IDLE;
    assign flush_done = run && (((ctrl.nxt == NXT_LEN) && len_zero) ||
                                ((ctrl.nxt == NXT_CHR) && chr_end));

    // Byte selection for the current step.
    always_comb begin
        case (ctrl.src)
            SRC_ID_HI: step_byte = r_query_id[15:8];
            SRC_ID_LO: step_byte = r_query_id[7:0];
            SRC_LEN:   step_byte = 8'(r_len);
            SRC_CHAR:  step_byte = rd_data;
            SRC_QT_HI: step_byte = r_query_type[15:8];
            SRC_QT_LO: step_byte = r_query_type[7:0];
            SRC_QC_HI: step_byte = r_query_class[15:8];
            SRC_QC_LO: step_byte = r_query_class[7:0];
            default:   step_byte = ctrl.konst;
        endcase
    end

    // The byte closes the run when nothing else follows for this character.
    always_comb begin
        case (ctrl.eor)
            EOR_ALWAYS:  step_eor = 1'b1;
            EOR_HDR_END: step_eor = !r_flush && !r_last;
            EOR_LEN_END: step_eor = len_zero && !r_last;
            EOR_CHR_END: step_eor = chr_end && !r_last;
            default:     step_eor = 1'b0;
        endcase
    end

    // Next step.
    always_comb begin
        n_pc = r_pc;
        if (accept_in) begin
            if (!r_hdr) begin
                n_pc = PC_ID_HI;
            end else if (in_flush) begin
                n_pc = PC_LEN;
            end else if (i_in_req.last_char) begin
                n_pc = PC_TERM;
            end else begin
                n_pc = PC_IDLE;
            end
        end else if (run) begin
            case (ctrl.nxt)
                NXT_SEQ:      n_pc = r_pc + t_pc'(1);
                NXT_DISPATCH: n_pc = r_flush ? PC_LEN : (r_last ? PC_TERM : PC_IDLE);
                NXT_LEN:      n_pc = len_zero ? post_flush : PC_CHR;
                NXT_CHR:      n_pc = chr_end ? post_flush : PC_CHR;
                default:      n_pc = PC_IDLE;
            endcase
        end
    end

    // Label state, message flag and character index.
    always_comb begin
        n_len = r_len;
        n_ovf = r_ovf;
        n_hdr = r_hdr;
        n_idx = r_idx;
        if (accept_in) begin
            n_len = in_len;
            n_ovf = r_ovf || (!in_dot && !in_store);
            n_hdr = 1'b1;
        end else begin
            if (flush_done) begin
                n_len = '0;
                n_ovf = 1'b0;
            end
            if (run && ctrl.eom) begin
                n_hdr = 1'b0;
            end
            if (run && (r_pc == PC_LEN)) begin
                n_idx = '0;
            end else if (run && (r_pc == PC_CHR)) begin
                n_idx = r_idx + AW'(1);
            end
        end
    end

    // Read address runs one character ahead of the emitted byte.
    always_comb begin
        if (r_pc == PC_LEN) begin
            rd_addr = '0;
        end else if (r_idx == AW'(MAX_LABEL - 1)) begin
            rd_addr = r_idx;
        end else begin
            rd_addr = r_idx + AW'(1);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= PC_IDLE;
            r_len <= '0;
            r_ovf <= 1'b0;
            r_hdr <= 1'b0;
        end else begin
            r_pc  <= n_pc;
            r_len <= n_len;
            r_ovf <= n_ovf;
            r_hdr <= n_hdr;
        end
    end

    // Per-character flags and index.
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (accept_in) begin
            r_last  <= i_in_req.last_char;
            r_flush <= in_flush;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (run) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (run) begin
            r_out_req <= '{out_byte:        step_byte,
                           end_of_run:      step_eor,
                           end_of_message:  ctrl.eom,
                           label_truncated: ctrl.trunc && r_ovf};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    // Label buffer.
    dqmb_label_buf #(
        .DEPTH (MAX_LABEL),
        .AW    (AW)
    ) u_label_buf (
        .i_clk     (i_clk),
        .i_wr_en   (accept_in && in_store),
        .i_wr_addr (r_len[AW-1:0]),
        .i_wr_data (i_in_req.name_char),
        .i_rd_en   (run),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

// ===== hw/rtl/dqmb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS query message builder checker
// Port-level properties of the builder core, attached by a bind statement.
// ----------------------------------------------------------------------------
module dqmb_checker
    import dqmb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     o_in_ready,
    input  t_in_req  i_in_req,
    input  logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_out_req o_out_req
);

    // A stalled byte request holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_req))
        else $error("output request changed while stalled");

    // The final character always causes bytes, so the block goes busy.
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_req.last_char |=> !o_in_ready)
        else $error("input still ready after the final character");

    // The closing QCLASS byte also closes the run of its character.
    a_eom_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.end_of_message |-> o_out_req.end_of_run)
        else $error("end of message without end of run");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind dns_query_message_builder_core dqmb_checker u_dqmb_checker (.*);
